[hdl/fifo_queue_with_match_count_assert.svh]
// assertion macros shared by the checker
`ifndef FIFO_QUEUE_WITH_MATCH_COUNT_ASSERT_SVH
`define FIFO_QUEUE_WITH_MATCH_COUNT_ASSERT_SVH

// checked only outside reset
`define FQMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define FQMC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/fqmc_pkg.sv]
package fqmc_pkg;

    localparam int VALUE_W   = 32;
    localparam int REP_W     = 5;
    localparam int SIZE_W    = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 80;

    localparam logic signed [VALUE_W-1:0] EMPTY_MARK = -32'sd9999;

    typedef enum logic [1:0] {
        KIND_ENQ = 2'd0,
        KIND_DEQ = 2'd1,
        KIND_CNT = 2'd2,
        KIND_REP = 2'd3
    } req_kind_t;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PUSH  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_FETCH = 5'b01000,
        S_LOAD  = 5'b10000
    } state_t;

    typedef struct packed {
        logic                      overflow;
        logic [SIZE_W-1:0]         match_count;
        logic [SIZE_W-1:0]         queue_size;
        logic signed [VALUE_W-1:0] tail_value;
        logic signed [VALUE_W-1:0] head_value;
    } result_t;

endpackage

[hdl/fqmc_store.sv]
module fqmc_store
    import fqmc_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
)
(
    input  logic                      clk,
    input  logic                      we,
    input  logic [IDX_W-1:0]          waddr,
    input  logic signed [VALUE_W-1:0] wdata,
    input  logic [IDX_W-1:0]          raddr_a,
    input  logic [IDX_W-1:0]          raddr_b,
    output logic signed [VALUE_W-1:0] rdata_a,
    output logic signed [VALUE_W-1:0] rdata_b
);

    logic signed [VALUE_W-1:0] mem [DEPTH];
    logic signed [VALUE_W-1:0] rdata_a_reg;
    logic signed [VALUE_W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

[hdl/fqmc_seq.sv]
module fqmc_seq
    import fqmc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int IDX_W       = 4,
    parameter int CNT_W       = 5
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  req_kind_t                 in_kind,
    input  logic signed [VALUE_W-1:0] in_value,
    input  logic [REP_W-1:0]          in_repeat,
    input  logic                      out_free,
    output logic                      res_load,
    output result_t                   res,
    output logic                      st_we,
    output logic [IDX_W-1:0]          st_waddr,
    output logic signed [VALUE_W-1:0] st_wdata,
    output logic [IDX_W-1:0]          st_raddr_a,
    output logic [IDX_W-1:0]          st_raddr_b,
    input  logic signed [VALUE_W-1:0] st_rdata_a,
    input  logic signed [VALUE_W-1:0] st_rdata_b
);

    state_t                    state_reg,  state_next;
    logic [IDX_W-1:0]          head_reg,   head_next;
    logic [IDX_W-1:0]          tail_reg,   tail_next;
    logic [CNT_W-1:0]          count_reg,  count_next;
    logic [IDX_W-1:0]          pos_reg,    pos_next;
    logic [CNT_W-1:0]          scan_reg,   scan_next;
    logic [REP_W-1:0]          remain_reg, remain_next;
    logic signed [VALUE_W-1:0] value_reg,  value_next;
    logic [CNT_W-1:0]          match_reg,  match_next;
    logic                      drop_reg,   drop_next;
    logic                      cmp_reg,    cmp_next;
    logic                      empty;

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] i);
        wrap_next = (i == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        scan_next   = scan_reg;
        remain_next = remain_reg;
        value_next  = value_reg;
        match_next  = match_reg;
        drop_next   = drop_reg;
        cmp_next    = 1'b0;
        st_we       = 1'b0;
        res_load    = 1'b0;

        // compare unit: result of the read issued last cycle
        if (cmp_reg && (st_rdata_a == value_reg))
        begin
            match_next = match_reg + 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    value_next = in_value;
                    match_next = '0;
                    drop_next  = 1'b0;
                    case (in_kind)
                        KIND_ENQ:
                        begin
                            remain_next = REP_W'(1);
                            state_next  = S_PUSH;
                        end
                        KIND_REP:
                        begin
                            remain_next = in_repeat;
                            state_next  = S_PUSH;
                        end
                        KIND_DEQ:
                        begin
                            if (count_reg != '0)
                            begin
                                head_next  = wrap_next(head_reg);
                                count_next = count_reg - 1'b1;
                            end
                            state_next = S_FETCH;
                        end
                        KIND_CNT:
                        begin
                            pos_next   = head_reg;
                            scan_next  = '0;
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_FETCH;
                        end
                    endcase
                end
            end
            S_PUSH:
            begin
                if (remain_reg == '0)
                begin
                    state_next = S_FETCH;
                end
                else if (count_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    // remaining copies do not fit
                    drop_next  = 1'b1;
                    state_next = S_FETCH;
                end
                else
                begin
                    st_we       = 1'b1;
                    tail_next   = wrap_next(tail_reg);
                    count_next  = count_reg + 1'b1;
                    remain_next = remain_reg - 1'b1;
                end
            end
            S_SCAN:
            begin
                if (scan_reg == count_reg)
                begin
                    state_next = S_FETCH;
                end
                else
                begin
                    cmp_next  = 1'b1;
                    pos_next  = wrap_next(pos_reg);
                    scan_next = scan_reg + 1'b1;
                end
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    res_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign st_waddr   = tail_reg;
    assign st_wdata   = value_reg;
    assign st_raddr_a = (state_reg == S_SCAN) ? pos_reg : head_reg;
    assign st_raddr_b = (tail_reg == '0) ? IDX_W'(QUEUE_DEPTH - 1) : tail_reg - 1'b1;

    assign empty           = (count_reg == '0);
    assign res.head_value  = empty ? EMPTY_MARK : st_rdata_a;
    assign res.tail_value  = empty ? EMPTY_MARK : st_rdata_b;
    assign res.queue_size  = SIZE_W'(count_reg);
    assign res.match_count = SIZE_W'(match_reg);
    assign res.overflow    = drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            cmp_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            cmp_reg   <= cmp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        scan_reg   <= scan_next;
        remain_reg <= remain_next;
        value_reg  <= value_next;
        match_reg  <= match_next;
        drop_reg   <= drop_next;
    end

endmodule

[hdl/fifo_queue_with_match_count.sv]
// bounded fifo of signed 32-bit words with a match counter
// input channel s_*: s_tuser carries the request kind (enqueue, dequeue, count,
// repeated enqueue), s_tdata the value and the repeat count
// output channel m_*: one item per request with head, tail, size, match count
// and the overflow flag; head and tail read -9999 while the queue is empty
// an item is taken when s_tvalid and s_tready are high at the same edge;
// s_tready is low while a request is in progress
// each request passes through its states before the next accept: a dequeue goes
// to fetch and load; an enqueue or repeated enqueue writes its copies in push,
// stopping when the queue is full, then fetch and load; a count scans every
// stored entry, then fetch and load; m_tvalid rises as s_tready returns high
// the store has one write and two read ports, so the repeated enqueue writes
// one copy per cycle and the count compares one entry per cycle
// the result waits in an output register, so a new request is taken while
// the receiver stalls; the following result waits until that register drains
// reset empties the queue and drops any pending result; store contents are
// not cleared, only written entries are ever read
module fifo_queue_with_match_count
    import fqmc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // value[31:0], repeat_count[36:32]
    input  logic [1:0]           s_tuser,   // req_type[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // head_value[31:0], tail_value[63:32],
                                            // queue_size[68:64], match_count[73:69],
                                            // overflow[74]
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                      out_free;
    logic                      res_load;
    result_t                   res;
    logic                      st_we;
    logic [IDX_W-1:0]          st_waddr;
    logic signed [VALUE_W-1:0] st_wdata;
    logic [IDX_W-1:0]          st_raddr_a;
    logic [IDX_W-1:0]          st_raddr_b;
    logic signed [VALUE_W-1:0] st_rdata_a;
    logic signed [VALUE_W-1:0] st_rdata_b;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]      m_tdata_reg,  m_tdata_next;

    fqmc_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (req_kind_t'(s_tuser)),
        .in_value   (s_tdata[VALUE_W-1:0]),
        .in_repeat  (s_tdata[VALUE_W+REP_W-1:VALUE_W]),
        .out_free   (out_free),
        .res_load   (res_load),
        .res        (res),
        .st_we      (st_we),
        .st_waddr   (st_waddr),
        .st_wdata   (st_wdata),
        .st_raddr_a (st_raddr_a),
        .st_raddr_b (st_raddr_b),
        .st_rdata_a (st_rdata_a),
        .st_rdata_b (st_rdata_b)
    );

    fqmc_store #(
        .DEPTH (QUEUE_DEPTH),
        .IDX_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .we      (st_we),
        .waddr   (st_waddr),
        .wdata   (st_wdata),
        .raddr_a (st_raddr_a),
        .raddr_b (st_raddr_b),
        .rdata_a (st_rdata_a),
        .rdata_b (st_rdata_b)
    );

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'(res);
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hdl/fqmc_checker.sv]
`include "fifo_queue_with_match_count_assert.svh"

module fqmc_checker
    import fqmc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `FQMC_ASSERT_ALWAYS(a_no_item_in_reset, !rst_n |-> !m_tvalid, "result shown during reset")

    `FQMC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled item changed")

    `FQMC_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "request taken while busy")

    `FQMC_ASSERT(a_empty_mark, m_tvalid && (m_tdata[68:64] == 5'd0) |-> (m_tdata[31:0] == EMPTY_MARK) && (m_tdata[63:32] == EMPTY_MARK), "empty queue without empty mark")

endmodule

bind fifo_queue_with_match_count fqmc_checker u_fqmc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
